/* rtl/xrc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and the CRC-16 byte step for the XMODEM receive controller.
package xrc_pkg;

    localparam logic [7:0] HEAD_SOH   = 8'h01;
    localparam logic [7:0] HEAD_CTRLC = 8'h03;
    localparam logic [7:0] HEAD_EOT   = 8'h04;
    localparam logic [7:0] HEAD_CAN   = 8'h18;
    localparam logic [7:0] CHAR_LO_Q  = 8'h71;
    localparam logic [7:0] CHAR_UP_Q  = 8'h51;
    localparam logic [7:0] CHAR_LO_U  = 8'h75;
    localparam logic [7:0] CHAR_UP_U  = 8'h55;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    localparam logic [1:0] CHAN_SERIAL    = 2'd0;
    localparam logic [1:0] CHAN_PRIMARY   = 2'd1;
    localparam logic [1:0] CHAN_SECONDARY = 2'd2;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic REG_APP_START  = 1'b0;
    localparam logic REG_APP_LENGTH = 1'b1;

    localparam logic [23:0] APP_LENGTH_RESET = 24'd245760;

    // One frame request as handed from the front end to the back end.
    typedef struct packed {
        logic [7:0]  head;
        logic [7:0]  seq;
        logic [15:0] check;
        logic [1:0]  src;
        logic [15:0] crc;
        logic [7:0]  sum;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [31:0] app_start;
        logic [23:0] app_length;
    } cfg_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/xrc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts stream requests, accumulates CRC and sum, pushes frame requests.
module xrc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    input  logic [41:0]         in_data,
    input  xrc_pkg::q_status_t  q_status,
    output logic                in_ready,
    output logic                push,
    output xrc_pkg::frame_t     push_frame
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic        accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && in_cmd;

    assign push_frame.head  = in_data[15:8];
    assign push_frame.seq   = in_data[23:16];
    assign push_frame.check = in_data[39:24];
    assign push_frame.src   = in_data[41:40];
    assign push_frame.crc   = crc_reg;
    assign push_frame.sum   = sum_reg;

    always_comb
    begin
        crc_next = crc_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (in_cmd)
            begin
                // The frame takes the snapshot; the next packet starts clean.
                crc_next = 16'h0000;
                sum_next = 8'h00;
            end
            else
            begin
                crc_next = xrc_pkg::crc16_byte(crc_reg, in_data[7:0]);
                sum_next = sum_reg + in_data[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 16'h0000;
            sum_reg <= 8'h00;
        end
        else
        begin
            crc_reg <= crc_next;
            sum_reg <= sum_next;
        end
    end

endmodule

/* rtl/xrc_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of frame requests between the front end and the back end.
module xrc_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  xrc_pkg::frame_t     push_frame,
    input  logic                pop,
    output xrc_pkg::frame_t     head_frame,
    output xrc_pkg::q_status_t  status
);

    xrc_pkg::frame_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_frame   = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

/* rtl/xrc_back.sv */
`timescale 1ns / 1ps
// Back end: session state machine, packet checks, flash address and the result register.
module xrc_back
#(
    parameter int PACKET_BYTES = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  xrc_pkg::cfg_t       cfg,
    input  xrc_pkg::frame_t     frame,
    input  xrc_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [47:0]         out_data
);

    localparam int PB_W  = $clog2(PACKET_BYTES + 1);
    localparam int IDX_W = 25;
    localparam int OFF_W = IDX_W + PB_W;

    typedef enum logic [2:0]
    {
        S_INIT   = 3'd0,
        S_START  = 3'd1,
        S_PROG   = 3'd2,
        S_RETRY  = 3'd3,
        S_DONE   = 3'd4,
        S_CANCEL = 3'd5
    } session_t;

    session_t    state_reg;
    session_t    state_next;
    logic        mode_reg;
    logic        mode_next;
    logic [7:0]  prev_reg;
    logic [7:0]  prev_next;
    logic [23:0] wrap_reg;
    logic [23:0] wrap_next;
    logic [1:0]  chan_reg;
    logic [1:0]  chan_next;
    logic        lock_reg;
    logic        lock_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [47:0] out_data_reg;

    logic [1:0]       reply;
    logic [1:0]       rchan;
    logic             erase;
    logic             prog;
    logic [31:0]      addr;
    logic             ok;
    logic             ok_crc;
    logic             ok_sum;
    logic             ok_cur;
    logic             ok_alt;
    logic [1:0]       cur_chan;
    logic [23:0]      wrap_use;
    logic [IDX_W-1:0] pkt_index;
    logic [OFF_W-1:0] offset;
    logic             too_far;

    function automatic logic [1:0] rotate(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            xrc_pkg::CHAN_PRIMARY:   r = xrc_pkg::CHAN_SECONDARY;
            xrc_pkg::CHAN_SECONDARY: r = xrc_pkg::CHAN_SERIAL;
            default:                 r = xrc_pkg::CHAN_PRIMARY;
        endcase
        return r;
    endfunction

    assign pop       = !q_status.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The CRC arrives byte-swapped; the checksum sits in the low byte.
    assign ok_crc = (frame.crc == {frame.check[7:0], frame.check[15:8]});
    assign ok_sum = (frame.sum == frame.check[7:0]);
    assign ok_cur = mode_reg ? ok_crc : ok_sum;
    assign ok_alt = mode_reg ? ok_sum : ok_crc;

    // Offset math for an in-order packet. The index drops below zero only when the wrap count
    // rolls over to zero; the offset then reads as minus one packet, and the end of that
    // packet lands at zero, which always fits the region.
    assign wrap_use  = (frame.seq == 8'd0) ? wrap_reg + 24'd256 : wrap_reg;
    assign pkt_index = {1'b0, wrap_use} + {17'b0, frame.seq} - IDX_W'(1);
    assign offset    = OFF_W'(pkt_index) * OFF_W'(PACKET_BYTES);
    assign too_far   = (pkt_index == {IDX_W{1'b1}}) ? 1'b0 :
                       (({1'b0, offset} + (OFF_W + 1)'(PACKET_BYTES))
                        > (OFF_W + 1)'(cfg.app_length));

    always_comb
    begin
        reply      = xrc_pkg::REPLY_NONE;
        rchan      = chan_reg;
        erase      = 1'b0;
        prog       = 1'b0;
        addr       = 32'h0;
        state_next = state_reg;
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        wrap_next  = wrap_reg;
        chan_next  = chan_reg;
        lock_next  = lock_reg;
        ok         = ok_cur;
        cur_chan   = chan_reg;

        case (frame.head) inside
            xrc_pkg::HEAD_SOH:
            begin
                if (!ok_cur && state_reg == S_START && ok_alt)
                begin
                    // The sender uses the other check; follow it.
                    mode_next = !mode_reg;
                    ok        = 1'b1;
                end
                if (!ok && state_reg == S_START)
                begin
                    // Neither check passes while waiting for the first packet: stay silent.
                    state_next = state_reg;
                end
                else if (!ok)
                begin
                    reply      = xrc_pkg::REPLY_NAK;
                    chan_next  = lock_reg ? chan_reg : rotate(chan_reg);
                    state_next = S_RETRY;
                end
                else
                begin
                    if (state_reg == S_START)
                    begin
                        lock_next = 1'b1;
                        cur_chan  = (frame.src == 2'd3) ? xrc_pkg::CHAN_SERIAL : frame.src;
                        erase     = 1'b1;
                    end
                    rchan     = cur_chan;
                    chan_next = cur_chan;
                    if (frame.seq == prev_reg)
                    begin
                        state_next = S_PROG;
                    end
                    else if (prev_reg + 8'd1 != frame.seq)
                    begin
                        state_next = S_RETRY;
                    end
                    else
                    begin
                        prev_next = frame.seq;
                        wrap_next = wrap_use;
                        chan_next = lock_next ? cur_chan : rotate(cur_chan);
                        if (too_far)
                        begin
                            reply      = xrc_pkg::REPLY_NAK;
                            state_next = S_RETRY;
                        end
                        else
                        begin
                            reply      = xrc_pkg::REPLY_ACK;
                            prog       = 1'b1;
                            addr       = cfg.app_start + offset[31:0];
                            state_next = S_PROG;
                        end
                    end
                end
            end
            xrc_pkg::HEAD_EOT:
            begin
                reply      = xrc_pkg::REPLY_ACK;
                chan_next  = lock_reg ? chan_reg : rotate(chan_reg);
                wrap_next  = 24'h0;
                state_next = S_DONE;
            end
            xrc_pkg::HEAD_CAN, xrc_pkg::CHAR_LO_Q, xrc_pkg::CHAR_UP_Q:
            begin
                reply      = xrc_pkg::REPLY_ACK;
                chan_next  = lock_reg ? chan_reg : rotate(chan_reg);
                wrap_next  = 24'h0;
                state_next = S_CANCEL;
            end
            xrc_pkg::HEAD_CTRLC, xrc_pkg::CHAR_LO_U, xrc_pkg::CHAR_UP_U:
            begin
                if (state_reg == S_INIT)
                begin
                    state_next = S_START;
                end
                else if (state_reg == S_PROG)
                begin
                    state_next = S_CANCEL;
                end
            end
            xrc_pkg::CHAR_LO_A, xrc_pkg::CHAR_UP_A:
            begin
                if (state_reg == S_INIT || state_reg == S_START)
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            mode_reg      <= 1'b0;
            prev_reg      <= 8'd0;
            wrap_reg      <= 24'd0;
            chan_reg      <= xrc_pkg::CHAN_SERIAL;
            lock_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                state_reg <= state_next;
                mode_reg  <= mode_next;
                prev_reg  <= prev_next;
                wrap_reg  <= wrap_next;
                chan_reg  <= chan_next;
                lock_reg  <= lock_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {6'b0, mode_next, addr, prog, erase, state_next, rchan, reply};
        end
    end

endmodule

/* rtl/xmodem_receive_controller.sv */
`timescale 1ns / 1ps
// Top level of the XMODEM receive controller: configuration registers and block wiring.
//
// Channel   Kind           Payload
// s_*       stream in      tuser: cmd; tdata: data, head, seq, check, source channel
// m_*       stream out     tdata: reply, channel, state, erase, program, address, mode
// p*        APB register   0x0 app_start_address, 0x4 app_length_bytes
//
// One request is accepted per cycle while the queue is not full. Data bytes finish in the
// front end in the cycle they are accepted; a frame is written into a two-entry queue and
// then taken by the back end, whose session update sets the rate and registers the result.
// s_tready drops only while the queue is full, which happens only after the output has stalled.
// Reset clears the session, the running checks and the queue; no clearing pass is needed.
module xmodem_receive_controller
#(
    parameter int PACKET_BYTES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [7:0] data_byte, [15:8] head_byte, [23:16] seq_number,
                                   // [39:24] check_word, [41:40] source_channel, rest zero
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [1:0] reply_code, [3:2] reply_channel, [6:4] update_state,
                                   // [7] erase_request, [8] program_request,
                                   // [40:9] program_address, [41] crc_mode, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    xrc_pkg::cfg_t      cfg_reg;
    xrc_pkg::frame_t    push_frame;
    xrc_pkg::frame_t    head_frame;
    xrc_pkg::q_status_t q_status;
    logic               push;
    logic               pop;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            xrc_pkg::REG_APP_START:  prdata = cfg_reg.app_start;
            xrc_pkg::REG_APP_LENGTH: prdata = {8'h00, cfg_reg.app_length};
            default:                 prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.app_start  <= 32'h0;
            cfg_reg.app_length <= xrc_pkg::APP_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == xrc_pkg::REG_APP_START)
            begin
                cfg_reg.app_start <= pwdata;
            end
            else
            begin
                cfg_reg.app_length <= pwdata[23:0];
            end
        end
    end

    xrc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_cmd     (s_tuser),
        .in_data    (s_tdata[41:0]),
        .q_status   (q_status),
        .in_ready   (s_tready),
        .push       (push),
        .push_frame (push_frame)
    );

    xrc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .status     (q_status)
    );

    xrc_back #(.PACKET_BYTES(PACKET_BYTES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .frame     (head_frame),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !s_tready)
        else $error("input accepted while the frame queue is full");

    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(pop))
        else $error("result appeared without a frame taken from the queue");

    a_program_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[1:0] == xrc_pkg::REPLY_ACK))
        else $error("program request without an ACK reply");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the XMODEM receive controller: directed rows, then random sessions.
module tb;

    localparam int PACKET      = 128;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        S_INIT,
        S_START,
        S_PROG,
        S_RETRY,
        S_DONE,
        S_CANCEL
    } session_t;

    typedef enum logic [1:0] {
        CK_RAW,
        CK_CRC,
        CK_BAD
    } check_kind_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic [7:0]  head;
        logic [7:0]  seq;
        logic [15:0] check;
        logic [1:0]  src;
    } in_item_t;

    // Field order follows m_tdata from bit 41 down to bit 0.
    typedef struct packed {
        logic        mode;
        logic [31:0] addr;
        logic        prog;
        logic        erase;
        logic [2:0]  state;
        logic [1:0]  chan;
        logic [1:0]  reply;
    } result_t;

    typedef struct packed {
        in_item_t    item;
        check_kind_t kind;
        logic        typed;
        result_t     want;
    } row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the session and the registers.
    session_t    session     = S_INIT;
    logic        crc_on      = 1'b0;
    logic [7:0]  last_seq    = 8'd0;
    logic [23:0] wrap_base   = 24'd0;
    logic [15:0] crc_acc     = 16'd0;
    logic [7:0]  sum_acc     = 8'd0;
    logic [1:0]  active_chan = xrc_pkg::CHAN_SERIAL;
    logic        chan_locked = 1'b0;
    logic [31:0] img_base    = 32'd0;
    logic [23:0] img_len     = xrc_pkg::APP_LENGTH_RESET;

    result_t     pending_replies[$];
    row_t        dir_rows[$];
    result_t     seen_reply;
    result_t     wanted_reply;
    int          mismatches     = 0;
    int          accepted_items = 0;
    int unsigned cycle_count    = 0;
    bit          calm           = 1'b0;

    xmodem_receive_controller #(.PACKET_BYTES(PACKET)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_reply = result_t'(m_tdata[41:0]);
            if (pending_replies.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("mismatch: reply %h arrived with none outstanding", seen_reply);
                end
                mismatches++;
            end
            else
            begin
                wanted_reply = pending_replies.pop_front();
                if (seen_reply !== wanted_reply)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch: expected reply %0d chan %0d state %0d erase %0b",
                                 wanted_reply.reply, wanted_reply.chan, wanted_reply.state,
                                 wanted_reply.erase);
                        $display("          prog %0b addr %h mode %0b",
                                 wanted_reply.prog, wanted_reply.addr, wanted_reply.mode);
                        $display("          got reply %0d chan %0d state %0d erase %0b",
                                 seen_reply.reply, seen_reply.chan, seen_reply.state,
                                 seen_reply.erase);
                        $display("          prog %0b addr %h mode %0b",
                                 seen_reply.prog, seen_reply.addr, seen_reply.mode);
                    end
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [15:0] crc16_shift(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] acc;
        logic        fb;
        acc = c;
        for (int b = 7; b >= 0; b--)
        begin
            fb  = acc[15] ^ d[b];
            acc = {acc[14:0], 1'b0};
            if (fb)
            begin
                acc = acc ^ xrc_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic check_matches(input logic crc_mode, input logic [15:0] word);
        if (crc_mode)
        begin
            return crc_acc == {word[7:0], word[15:8]};
        end
        return sum_acc == word[7:0];
    endfunction

    // The reply leaves on the active channel, which moves on while no channel is locked.
    function automatic logic [1:0] take_reply_channel();
        logic [1:0] used;
        used = active_chan;
        if (!chan_locked)
        begin
            case (active_chan)
                xrc_pkg::CHAN_PRIMARY:   active_chan = xrc_pkg::CHAN_SECONDARY;
                xrc_pkg::CHAN_SECONDARY: active_chan = xrc_pkg::CHAN_SERIAL;
                default:                 active_chan = xrc_pkg::CHAN_PRIMARY;
            endcase
        end
        return used;
    endfunction

    function automatic result_t frame_outcome(input in_item_t it);
        result_t     r;
        session_t    nxt;
        logic        ok;
        logic        mute;
        logic [7:0]  next_seq;
        logic [39:0] offs;
        r        = '0;
        r.chan   = active_chan;
        nxt      = session;
        mute     = 1'b0;
        next_seq = last_seq + 8'd1;
        case (it.head)
            xrc_pkg::HEAD_SOH:
            begin
                ok = check_matches(crc_on, it.check);
                // In the start state a packet failing the current check may pass the other one.
                if (!ok && session == S_START)
                begin
                    if (check_matches(!crc_on, it.check))
                    begin
                        crc_on = !crc_on;
                        ok     = 1'b1;
                    end
                    else
                    begin
                        mute = 1'b1;
                    end
                end
                if (!mute)
                begin
                    if (!ok)
                    begin
                        r.reply = xrc_pkg::REPLY_NAK;
                        r.chan  = take_reply_channel();
                        nxt     = S_RETRY;
                    end
                    else
                    begin
                        if (session == S_START)
                        begin
                            chan_locked = 1'b1;
                            active_chan = (it.src == 2'd3) ? xrc_pkg::CHAN_SERIAL : it.src;
                            r.chan      = active_chan;
                            r.erase     = 1'b1;
                        end
                        if (it.seq == last_seq)
                        begin
                            nxt = S_PROG;
                        end
                        else if (it.seq != next_seq)
                        begin
                            nxt = S_RETRY;
                        end
                        else
                        begin
                            last_seq = it.seq;
                            if (it.seq == 8'd0)
                            begin
                                wrap_base = wrap_base + 24'd256;
                            end
                            offs = (40'(wrap_base) + 40'(it.seq) - 40'd1) * 40'(PACKET);
                            if (offs + 40'(PACKET) > 40'(img_len))
                            begin
                                r.reply = xrc_pkg::REPLY_NAK;
                                r.chan  = take_reply_channel();
                                nxt     = S_RETRY;
                            end
                            else
                            begin
                                r.reply = xrc_pkg::REPLY_ACK;
                                r.chan  = take_reply_channel();
                                r.prog  = 1'b1;
                                r.addr  = img_base + offs[31:0];
                                nxt     = S_PROG;
                            end
                        end
                    end
                end
            end
            xrc_pkg::HEAD_EOT:
            begin
                r.reply   = xrc_pkg::REPLY_ACK;
                r.chan    = take_reply_channel();
                wrap_base = 24'd0;
                nxt       = S_DONE;
            end
            xrc_pkg::HEAD_CAN, xrc_pkg::CHAR_LO_Q, xrc_pkg::CHAR_UP_Q:
            begin
                r.reply   = xrc_pkg::REPLY_ACK;
                r.chan    = take_reply_channel();
                wrap_base = 24'd0;
                nxt       = S_CANCEL;
            end
            xrc_pkg::HEAD_CTRLC, xrc_pkg::CHAR_LO_U, xrc_pkg::CHAR_UP_U:
            begin
                if (session == S_INIT)
                begin
                    nxt = S_START;
                end
                else if (session == S_PROG)
                begin
                    nxt = S_CANCEL;
                end
            end
            xrc_pkg::CHAR_LO_A, xrc_pkg::CHAR_UP_A:
            begin
                if (session == S_INIT || session == S_START)
                begin
                    nxt = S_DONE;
                end
            end
            default:
            begin
            end
        endcase
        session = nxt;
        crc_acc = 16'd0;
        sum_acc = 8'd0;
        r.state = nxt;
        r.mode  = crc_on;
        return r;
    endfunction

    function automatic logic [15:0] good_check();
        if (crc_on)
        begin
            return {crc_acc[7:0], crc_acc[15:8]};
        end
        return {8'($urandom), sum_acc};
    endfunction

    function automatic in_item_t random_item();
        in_item_t r;
        r.cmd   = 1'b1;
        r.data  = 8'($urandom);
        r.head  = 8'($urandom);
        r.seq   = 8'($urandom);
        r.check = 16'($urandom);
        r.src   = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic result_t quiet_reply(input session_t st);
        result_t r;
        r       = '0;
        r.state = st;
        return r;
    endfunction

    function automatic void add_data(input logic [7:0] d);
        row_t row;
        row           = '0;
        row.item.data = d;
        row.kind      = CK_RAW;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_frame(input logic [7:0] head, input logic [7:0] seq,
                                      input logic [15:0] check, input check_kind_t kind,
                                      input logic [1:0] src, input logic typed,
                                      input result_t want);
        row_t row;
        row.item.cmd   = 1'b1;
        row.item.data  = 8'd0;
        row.item.head  = head;
        row.item.seq   = seq;
        row.item.check = check;
        row.item.src   = src;
        row.kind       = kind;
        row.typed      = typed;
        row.want       = want;
        dir_rows.push_back(row);
    endfunction

    task automatic send_item(input in_item_t it, input logic typed, input result_t want);
        result_t predicted;
        if (!calm && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 23)
            begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'd0, it.src, it.check, it.seq, it.head, it.data};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        accepted_items++;
        if (it.cmd == 1'b0)
        begin
            crc_acc = crc16_shift(crc_acc, it.data);
            sum_acc = sum_acc + it.data;
        end
        else
        begin
            predicted = frame_outcome(it);
            pending_replies.push_back(typed ? want : predicted);
        end
    endtask

    // Holds the sender off until every outstanding reply is out, plus the frame latency.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_read_check(input logic idx);
        logic [31:0] readback;
        logic [31:0] wanted;
        wanted = (idx == xrc_pkg::REG_APP_START) ? img_base : {8'h00, img_len};
        apb_read({idx, 2'b00}, readback);
        if (readback !== wanted)
        begin
            if (mismatches < 10)
            begin
                $display("mismatch: register %0d read %h, expected %h", idx, readback, wanted);
            end
            mismatches++;
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        apb_write({idx, 2'b00}, value);
        if (idx == xrc_pkg::REG_APP_START)
        begin
            img_base = value;
        end
        else
        begin
            img_len = value[23:0];
        end
        cfg_read_check(idx);
    endtask

    task automatic run_phase(input int goal);
        int       first;
        int       pick;
        int       sizer;
        int       n;
        in_item_t it;
        in_item_t byte_item;
        first = accepted_items;
        while (accepted_items - first < goal)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                drain_replies();
            end
            pick = $urandom_range(0, 99);
            it   = random_item();
            if (pick >= 90)
            begin
                // Noise: a stray payload byte or a frame with any head at all.
                it.cmd = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, '0);
            end
            else if (pick >= 84)
            begin
                case ($urandom_range(0, 8))
                    0:       it.head = xrc_pkg::HEAD_EOT;
                    1:       it.head = xrc_pkg::HEAD_CAN;
                    2:       it.head = xrc_pkg::CHAR_LO_Q;
                    3:       it.head = xrc_pkg::CHAR_UP_Q;
                    4:       it.head = xrc_pkg::HEAD_CTRLC;
                    5:       it.head = xrc_pkg::CHAR_LO_U;
                    6:       it.head = xrc_pkg::CHAR_UP_U;
                    7:       it.head = xrc_pkg::CHAR_LO_A;
                    default: it.head = xrc_pkg::CHAR_UP_A;
                endcase
                send_item(it, 1'b0, '0);
            end
            else
            begin
                // Mostly empty payloads, so that the sequence number wraps within the run.
                sizer = $urandom_range(0, 99);
                n = (sizer < 80) ? 0 : (sizer < 95) ? $urandom_range(1, 4) : $urandom_range(5, 12);
                repeat (n)
                begin
                    byte_item     = random_item();
                    byte_item.cmd = 1'b0;
                    send_item(byte_item, 1'b0, '0);
                end
                it.head  = xrc_pkg::HEAD_SOH;
                it.seq   = last_seq + 8'd1;
                it.check = good_check();
                if (pick >= 76)
                begin
                    it.check = it.check ^ 16'($urandom_range(1, 65535));
                end
                else if (pick >= 70)
                begin
                    it.seq = 8'($urandom);
                end
                else if (pick >= 62)
                begin
                    it.seq = last_seq;
                end
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        in_item_t    it;
        logic [31:0] boundary;

        // Session opens from init, ignores a packet that fails both checks, then locks on the first good packet.
        add_frame(8'hFF, 8'hFF, 16'hFFFF, CK_RAW, 2'd3, 1'b1, quiet_reply(S_INIT));
        add_frame(xrc_pkg::HEAD_CTRLC, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL,
                  1'b1, quiet_reply(S_START));
        add_frame(xrc_pkg::CHAR_LO_U, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_PRIMARY,
                  1'b1, quiet_reply(S_START));
        add_frame(xrc_pkg::HEAD_SOH, 8'h01, 16'h1234, CK_RAW, xrc_pkg::CHAN_SECONDARY,
                  1'b1, quiet_reply(S_START));
        add_data(8'hFF);
        add_data(8'h00);
        add_data(8'hA5);
        // Passes only as CRC, so the mode switches, and source three locks to serial.
        add_frame(xrc_pkg::HEAD_SOH, 8'h01, 16'h0000, CK_CRC, 2'd3, 1'b0, '0);
        add_frame(xrc_pkg::HEAD_SOH, 8'h01, 16'h0000, CK_CRC, xrc_pkg::CHAN_PRIMARY,
                  1'b0, '0);
        add_frame(xrc_pkg::HEAD_SOH, 8'h03, 16'h0000, CK_CRC, xrc_pkg::CHAN_PRIMARY,
                  1'b0, '0);
        add_data(8'h5A);
        add_frame(xrc_pkg::HEAD_SOH, 8'h02, 16'h0000, CK_BAD, xrc_pkg::CHAN_SECONDARY,
                  1'b0, '0);
        add_data(8'h80);
        add_data(8'h01);
        add_frame(xrc_pkg::HEAD_SOH, 8'h02, 16'h0000, CK_CRC, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::HEAD_CTRLC, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::CHAR_UP_A, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::CHAR_LO_Q, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::CHAR_UP_Q, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::HEAD_CAN, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::HEAD_EOT, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::CHAR_UP_U, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(xrc_pkg::CHAR_LO_A, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);
        add_frame(8'h00, 8'h00, 16'h0000, CK_RAW, xrc_pkg::CHAN_SERIAL, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        cfg_read_check(xrc_pkg::REG_APP_START);
        cfg_read_check(xrc_pkg::REG_APP_LENGTH);

        foreach (dir_rows[i])
        begin
            it = dir_rows[i].item;
            case (dir_rows[i].kind)
                CK_CRC:  it.check = {crc_acc[7:0], crc_acc[15:8]};
                CK_BAD:  it.check = {crc_acc[7:0], crc_acc[15:8]} ^ 16'h0101;
                default: it.check = dir_rows[i].item.check;
            endcase
            send_item(it, dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(180);

        // Top of the address space with the largest region; no idling on either side.
        drain_replies();
        cfg_write(xrc_pkg::REG_APP_START, 32'hFFFF_FF00 | 32'($urandom_range(0, 255)));
        cfg_write(xrc_pkg::REG_APP_LENGTH, {8'($urandom), 24'hFF_FFFF});
        calm = 1'b1;
        run_phase(180);
        calm = 1'b0;

        // An empty region turns every in-order packet into a NAK.
        drain_replies();
        cfg_write(xrc_pkg::REG_APP_START, 32'h0000_0000);
        cfg_write(xrc_pkg::REG_APP_LENGTH, {8'($urandom), 24'h00_0000});
        run_phase(150);

        // Region ends a few packets past the current position.
        drain_replies();
        cfg_write(xrc_pkg::REG_APP_START, $urandom);
        boundary = (wrap_base + last_seq + $urandom_range(0, 6)) * PACKET + $urandom_range(0, 255);
        cfg_write(xrc_pkg::REG_APP_LENGTH, {8'($urandom), boundary[23:0]});
        run_phase(150);

        drain_replies();
        cfg_write(xrc_pkg::REG_APP_START, 32'hFFFF_FFFF);
        cfg_write(xrc_pkg::REG_APP_LENGTH, {8'($urandom), xrc_pkg::APP_LENGTH_RESET});
        run_phase(100);

        drain_replies();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/xrc_pkg.sv
rtl/xrc_front.sv
rtl/xrc_queue.sv
rtl/xrc_back.sv
rtl/xmodem_receive_controller.sv
test/tb.sv
